// ===== src/rmsa_pkg.sv =====
`default_nettype none
package rmsa_pkg;

   localparam int RamBytes = 65536;
   localparam int RamAw    = $clog2(RamBytes);
   localparam int RamWords = RamBytes / 8;
   localparam int WordAw   = RamAw - 3;

   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_RESERVE = 2'd2;

   localparam logic [6:0] OPC_AMO = 7'h2f;

   localparam logic [4:0] AMO_ADD  = 5'd0;
   localparam logic [4:0] AMO_SWAP = 5'd1;
   localparam logic [4:0] AMO_LR   = 5'd2;
   localparam logic [4:0] AMO_SC   = 5'd3;
   localparam logic [4:0] AMO_XOR  = 5'd4;
   localparam logic [4:0] AMO_OR   = 5'd8;
   localparam logic [4:0] AMO_AND  = 5'd12;
   localparam logic [4:0] AMO_MIN  = 5'd16;
   localparam logic [4:0] AMO_MAX  = 5'd20;
   localparam logic [4:0] AMO_MINU = 5'd24;
   localparam logic [4:0] AMO_MAXU = 5'd28;

   localparam logic [2:0] FK_NONE     = 3'd0;
   localparam logic [2:0] FK_ILLEGAL  = 3'd1;
   localparam logic [2:0] FK_LD_MIS   = 3'd2;
   localparam logic [2:0] FK_LD_ACC   = 3'd3;
   localparam logic [2:0] FK_ST_MIS   = 3'd4;
   localparam logic [2:0] FK_ST_ACC   = 3'd5;

   localparam logic CSR_MEM_BASE = 1'b0;
   localparam logic CSR_MEM_SIZE = 1'b1;

   localparam logic [63:0] NAN_BOX = 64'hffffffff00000000;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] addr;
      logic [3:0]  access_size;
      logic [63:0] data;
      logic [6:0]  opcode;
      logic [2:0]  funct3;
      logic [4:0]  funct5;
      logic        is_load;
      logic        is_store;
      logic        float_word;
      logic [31:0] raw_insn;
      logic        active;
   } req_type;

   typedef struct packed {
      logic [2:0]  fault_kind;
      logic [63:0] fault_value;
      logic [63:0] value;
      logic [63:0] new_data;
      logic        store_enable;
      logic        write_ok;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request, issue RAM read
      logic finish;    // compute result into output register
   } cmd_type;

endpackage
`default_nettype wire

// ===== src/rmsa_datapath.sv =====
`default_nettype none
module rmsa_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rmsa_pkg::req_type req,
   input  wire rmsa_pkg::cmd_type cmd,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [63:0]       csr_data,
   output rmsa_pkg::rsp_type      rsp
);
   localparam int EffW = rmsa_pkg::RamAw + 1;

   logic [63:0] mem_base_ff;
   logic [16:0] mem_size_ff;
   rmsa_pkg::req_type r_ff;
   logic        in_range_ff;
   logic        res_valid_ff, res_valid_in;
   logic [63:0] res_addr_ff;
   logic [3:0]  res_bytes_ff;
   logic [127:0] rd_ff;
   logic [2:0]  lane_ff;
   rmsa_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] ram_lo [rmsa_pkg::RamWords][8];

   // range check on incoming request
   logic [EffW-1:0] eff_size;
   logic [63:0] off_c;
   logic        rng_c;
   always_comb begin
      if ({47'd0, mem_size_ff} > 64'(rmsa_pkg::RamBytes))
         eff_size = EffW'(rmsa_pkg::RamBytes);
      else
         eff_size = EffW'(mem_size_ff);
      off_c = req.addr - mem_base_ff;
      rng_c = (req.access_size != 4'd0) && (req.access_size <= 4'd8) &&
              (req.addr >= mem_base_ff) &&
              ({60'd0, req.access_size} <= 64'(eff_size)) &&
              (off_c <= 64'(eff_size) - {60'd0, req.access_size});
   end

   // RAM: words of 8 byte lanes; two adjacent words are read, so an access may span both
   logic [63:0] r_off;
   logic [rmsa_pkg::WordAw-1:0] w0, w1;
   assign r_off = req.addr - mem_base_ff;
   assign w0 = r_off[rmsa_pkg::RamAw-1:3];
   assign w1 = w0 + 1'b1;

   logic [63:0] c_off;
   assign c_off = r_ff.addr - mem_base_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < 8; i++) begin
            rd_ff[i*8 +: 8]      <= ram_lo[w0][i];
            rd_ff[64 + i*8 +: 8] <= ram_lo[w1][i];
         end
         lane_ff <= r_off[2:0];
      end
      if (cmd.finish && r_ff.op == rmsa_pkg::OP_COMMIT && in_range_ff) begin
         for (int i = 0; i < 8; i++) begin
            logic [rmsa_pkg::RamAw-1:0] ba;
            ba = c_off[rmsa_pkg::RamAw-1:0] + rmsa_pkg::RamAw'(i);
            if (4'(i) < r_ff.access_size)
               ram_lo[ba[rmsa_pkg::RamAw-1:3]][ba[2:0]] <= r_ff.data[i*8 +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         r_ff        <= req;
         in_range_ff <= rng_c;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_base_ff  <= 64'h80000000;
         mem_size_ff  <= 17'd65536;
         res_valid_ff <= 1'b0;
         res_addr_ff  <= '0;
         res_bytes_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == rmsa_pkg::CSR_MEM_BASE) mem_base_ff <= csr_data;
            else mem_size_ff <= csr_data[16:0];
         end
         res_valid_ff <= res_valid_in;
         if (cmd.finish && r_ff.op == rmsa_pkg::OP_RESERVE) begin
            res_addr_ff  <= r_ff.addr;
            res_bytes_ff <= r_ff.access_size;
         end
      end
   end

   // result computation
   logic [127:0] sh;
   logic [63:0]  old, mask, v, b, nd, ld;
   logic [6:0]   nbits;
   logic         misal, sc_ok, ovl;
   always_comb begin
      sh    = rd_ff >> {lane_ff, 3'b000};
      nbits = {r_ff.access_size, 3'b000};
      mask  = (nbits >= 7'd64) ? '1 : ((64'd1 << nbits) - 64'd1);
      old   = sh[63:0] & mask;
      v     = (r_ff.access_size == 4'd4) ? {{32{old[31]}}, old[31:0]} : old;
      b     = (r_ff.access_size == 4'd4) ? {{32{r_ff.data[31]}}, r_ff.data[31:0]}
                                         : r_ff.data;
      misal = (r_ff.addr[3:0] & (r_ff.access_size - 4'd1)) != 4'd0;
      sc_ok = res_valid_ff && res_addr_ff == r_ff.addr &&
              res_bytes_ff == r_ff.access_size;
      ovl   = (r_ff.addr < res_addr_ff + {60'd0, res_bytes_ff}) &&
              (res_addr_ff < r_ff.addr + {60'd0, r_ff.access_size});
      ld = old;
      if (r_ff.float_word && r_ff.access_size == 4'd4) ld = old | rmsa_pkg::NAN_BOX;
      else if (!r_ff.float_word && r_ff.funct3 < 3'd4 && nbits != 7'd0 &&
               nbits < 7'd64) begin
         ld = (old ^ (64'd1 << (nbits - 7'd1))) - (64'd1 << (nbits - 7'd1));
      end

      res_valid_in = res_valid_ff;
      rsp_in = rsp_ff;
      nd = r_ff.data;
      if (cmd.finish) begin
         rsp_in = '0;
         case (r_ff.op)
            rmsa_pkg::OP_COMMIT: begin
               if (in_range_ff) begin
                  rsp_in.write_ok = 1'b1;
                  if (ovl) res_valid_in = 1'b0;
               end
            end
            rmsa_pkg::OP_RESERVE: res_valid_in = 1'b1;
            rmsa_pkg::OP_ACCESS: begin
               rsp_in.new_data     = r_ff.data;
               rsp_in.store_enable = r_ff.is_store;
               if (r_ff.active && (r_ff.is_load || r_ff.is_store)) begin
                  if (!in_range_ff) begin
                     rsp_in.fault_kind  = r_ff.is_store ? rmsa_pkg::FK_ST_ACC
                                                        : rmsa_pkg::FK_LD_ACC;
                     rsp_in.fault_value = r_ff.addr;
                     rsp_in.store_enable = 1'b0;
                  end else if (r_ff.opcode == rmsa_pkg::OPC_AMO) begin
                     if (misal) begin
                        rsp_in.fault_kind  = r_ff.is_store ? rmsa_pkg::FK_ST_MIS
                                                           : rmsa_pkg::FK_LD_MIS;
                        rsp_in.fault_value = r_ff.addr;
                        rsp_in.store_enable = 1'b0;
                     end else begin
                        rsp_in.value = v;
                        case (r_ff.funct5)
                           rmsa_pkg::AMO_LR:   ;
                           rmsa_pkg::AMO_SC: begin
                              rsp_in.value = {63'd0, !sc_ok};
                              rsp_in.store_enable = sc_ok;
                           end
                           rmsa_pkg::AMO_ADD:  nd = old + b;
                           rmsa_pkg::AMO_SWAP: nd = b;
                           rmsa_pkg::AMO_XOR:  nd = old ^ b;
                           rmsa_pkg::AMO_OR:   nd = old | b;
                           rmsa_pkg::AMO_AND:  nd = old & b;
                           rmsa_pkg::AMO_MIN:  nd = ($signed(v) < $signed(b)) ? v : b;
                           rmsa_pkg::AMO_MAX:  nd = ($signed(v) > $signed(b)) ? v : b;
                           rmsa_pkg::AMO_MINU: nd = (v < b) ? v : b;
                           rmsa_pkg::AMO_MAXU: nd = (v > b) ? v : b;
                           default: begin
                              rsp_in.fault_kind   = rmsa_pkg::FK_ILLEGAL;
                              rsp_in.fault_value  = {32'd0, r_ff.raw_insn};
                              rsp_in.store_enable = 1'b0;
                              rsp_in.value        = '0;
                           end
                        endcase
                        rsp_in.new_data = nd;
                     end
                  end else if (r_ff.is_load) begin
                     rsp_in.value = ld;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp = rsp_ff;
endmodule
`default_nettype wire

// ===== src/rmsa_ctrl.sv =====
`default_nettype none
module rmsa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rmsa_pkg::cmd_type      cmd,
   output logic                   csr_ready
);
   rmsa_pkg::state_type state_ff, state_in;
   logic valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmsa_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = (state_ff == rmsa_pkg::ST_IDLE) && !valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      case (state_ff)
         rmsa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = rmsa_pkg::ST_READ;
            end
         end
         rmsa_pkg::ST_READ: begin
            // result register must be free before it is overwritten
            if (!valid_in) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = rmsa_pkg::ST_IDLE;
            end
         end
         default: state_in = rmsa_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

// ===== src/riscv_memory_stage_with_atomics_unit.sv =====
// The request is captured and the RAM read issued when it is accepted in ST_IDLE;
// in ST_READ the result is computed, and any commit written, into the response
// register. A new request is not accepted until the current one has left ST_READ.
// A held response blocks completion of the next transaction.
// Synchronous active-high reset clears the reservation and handshake and sets the
// CSRs to their defaults; RAM contents are undefined until written.
`default_nettype none
module riscv_memory_stage_with_atomics_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rmsa_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rmsa_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [63:0]       csr_data
);
   rmsa_pkg::cmd_type cmd;

   rmsa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .csr_ready
   );

   rmsa_datapath u_dp (
      .clock, .reset, .req(req_payload), .cmd,
      .csr_write(csr_valid && csr_ready), .csr_index, .csr_data,
      .rsp(rsp_payload)
   );
endmodule
`default_nettype wire

// ===== src/rmsa_checker.sv =====
`default_nettype none
module rmsa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("rsp dropped");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("back-to-back accept");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)) else $error("rsp without request");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid) else $error("csr while busy");
endmodule

bind riscv_memory_stage_with_atomics_unit rmsa_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .csr_ready
);
`default_nettype wire
